// ===== rtl/core/fbsg_pkg.sv =====
// fbsg_pkg: widths, codes, constant tables and arithmetic helpers shared by
// the fourier basis sample generator core and its submodules
// no dependencies
`default_nettype none

package fbsg_pkg;

    localparam int unsigned LEN_W   = 11;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned SMP_W   = 16;
    localparam int unsigned CNT_W   = 2;
    localparam int unsigned MIN_LEN = 9;
    localparam int unsigned MAX_LEN = 1024;

    localparam int unsigned NIB_W   = 4;
    localparam int unsigned PRD_W   = 2 * IDX_W;
    localparam int unsigned MOD_STG = PRD_W / NIB_W;
    localparam int unsigned NUM_W   = 44;
    localparam int unsigned DIV_STG = NUM_W / NIB_W;
    localparam int unsigned HP_W    = 31;
    localparam int unsigned X_W     = 30;
    localparam int unsigned T_W     = 31;
    localparam int unsigned MAG_W   = 17;
    localparam int unsigned RCP_W   = 37;
    localparam int unsigned STEPS   = 5;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    localparam logic [T_W-1:0]  Q30_ONE     = 31'h4000_0000;
    localparam logic [HP_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [46:0]     ROUND_Q29   = 47'd536870912;
    localparam logic [63:0]     RCP_ONE     = 64'd1 << RCP_W;

    // reciprocals ceil(2^37/d) for the horner divisors
    localparam logic [RCP_W-1:0] SIN_RCP [STEPS] = '{
        37'((RCP_ONE + 64'd71) / 64'd72),
        37'((RCP_ONE + 64'd41) / 64'd42),
        37'((RCP_ONE + 64'd19) / 64'd20),
        37'((RCP_ONE + 64'd5) / 64'd6),
        37'd0
    };
    localparam logic [RCP_W-1:0] COS_RCP [STEPS] = '{
        37'((RCP_ONE + 64'd89) / 64'd90),
        37'((RCP_ONE + 64'd55) / 64'd56),
        37'((RCP_ONE + 64'd29) / 64'd30),
        37'((RCP_ONE + 64'd11) / 64'd12),
        37'((RCP_ONE + 64'd1) / 64'd2)
    };

    localparam logic [1:0] CLS_ILLEGAL = 2'd0;
    localparam logic [1:0] CLS_DC      = 2'd1;
    localparam logic [1:0] CLS_NYQ     = 2'd2;
    localparam logic [1:0] CLS_PAIR    = 2'd3;

    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic REG_BLOCK_LENGTH = 1'b0;
    localparam logic REG_LOWEST_INDEX = 1'b1;

    localparam logic [SMP_W-1:0] SMP_MAX = 16'h7FFF;
    localparam logic [SMP_W-1:0] SMP_MIN = 16'h8000;
    localparam logic [MAG_W-1:0] MAG_MAX = 17'd32767;

    typedef struct packed {
        logic [1:0]       cls;
        logic [IDX_W-1:0] freq;
        logic [IDX_W-1:0] tim;
    } t_entry;

    typedef struct packed {
        logic [1:0] cls;
        logic       kodd;
        logic [1:0] quad;
        logic       fold;
    } t_side;

    typedef struct packed {
        logic [X_W-1:0]   quo;
        logic [LEN_W-1:0] rem;
    } t_div;

    // four restoring remainder steps
    function automatic logic [LEN_W-1:0] mod_nib(input logic [LEN_W-1:0] rem,
                                                 input logic [NIB_W-1:0] nib,
                                                 input logic [LEN_W-1:0] n);
        logic [LEN_W:0] w;
        logic [LEN_W-1:0] r;
        r = rem;
        for (int b = NIB_W - 1; b >= 0; b--) begin
            w = {r, nib[b]};
            if (w >= {1'b0, n}) begin
                w = w - {1'b0, n};
            end
            r = w[LEN_W-1:0];
        end
        return r;
    endfunction

    // four restoring division steps, quotient bits shifted in
    function automatic t_div div_nib(input t_div d, input logic [NIB_W-1:0] nib,
                                     input logic [LEN_W-1:0] n);
        logic [LEN_W:0] w;
        t_div o;
        o = d;
        for (int b = NIB_W - 1; b >= 0; b--) begin
            w = {o.rem, nib[b]};
            if (w >= {1'b0, n}) begin
                w = w - {1'b0, n};
                o.quo = {o.quo[X_W-2:0], 1'b1};
            end else begin
                o.quo = {o.quo[X_W-2:0], 1'b0};
            end
            o.rem = w[LEN_W-1:0];
        end
        return o;
    endfunction

    function automatic logic [X_W-1:0] mul_q30(input logic [X_W-1:0] a,
                                               input logic [T_W-1:0] t);
        logic [X_W+T_W-1:0] p;
        p = {{T_W{1'b0}}, a} * {{X_W{1'b0}}, t};
        return p[2*X_W-1:X_W];
    endfunction

    function automatic logic [X_W-1:0] div_const(input logic [X_W-1:0] a,
                                                 input logic [RCP_W-1:0] m);
        logic [X_W+RCP_W-1:0] p;
        p = {{RCP_W{1'b0}}, a} * {{X_W{1'b0}}, m};
        return p[X_W+RCP_W-1:RCP_W];
    endfunction

    function automatic logic [MAG_W-1:0] to_mag(input logic [T_W-1:0] v);
        logic [46:0] w;
        w = {1'b0, v, 15'd0} + ROUND_Q29;
        return w[46:30];
    endfunction

    function automatic logic [SMP_W-1:0] to_sample(input logic [MAG_W-1:0] m,
                                                   input logic neg);
        logic [MAG_W-1:0] nm;
        nm = ~m + 17'd1;
        if (neg) begin
            return nm[SMP_W-1:0];
        end else if (m > MAG_MAX) begin
            return SMP_MAX;
        end
        return m[SMP_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fbsg_fifo.sv =====
// fbsg_fifo: four-entry queue of classified requests between front and back
// depends on fbsg_pkg
`default_nettype none

module fbsg_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fbsg_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output fbsg_pkg::t_entry     o_entry
);

    fbsg_pkg::t_entry r_mem [fbsg_pkg::FIFO_DEPTH];
    logic [fbsg_pkg::FIFO_AW-1:0] r_wptr, r_rptr;
    logic [fbsg_pkg::FIFO_AW:0]   r_cnt;
    logic w_push, w_pop;

    assign o_full  = (r_cnt == (fbsg_pkg::FIFO_AW + 1)'(fbsg_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fbsg_front.sv =====
// fbsg_front: input beat acceptance and index classification
// depends on fbsg_pkg
`default_nettype none

module fbsg_front (
    input  wire logic                        i_s_valid,
    input  wire logic [fbsg_pkg::IDX_W-1:0]  i_freq,
    input  wire logic [fbsg_pkg::IDX_W-1:0]  i_time,
    input  wire logic [fbsg_pkg::LEN_W-1:0]  i_block_length,
    input  wire logic [fbsg_pkg::IDX_W-1:0]  i_lowest_index,
    input  wire logic                        i_full,
    output logic                             o_s_ready,
    output logic                             o_push,
    output fbsg_pkg::t_entry                 o_entry
);

    logic [fbsg_pkg::LEN_W-1:0] w_half;
    logic w_illegal, w_nyq;

    assign w_half    = i_block_length >> 1;
    assign w_illegal = (i_block_length < fbsg_pkg::LEN_W'(fbsg_pkg::MIN_LEN))
                    || (i_block_length > fbsg_pkg::LEN_W'(fbsg_pkg::MAX_LEN))
                    || (i_freq < i_lowest_index)
                    || ({1'b0, i_freq} > w_half);
    assign w_nyq     = !i_block_length[0] && ({1'b0, i_freq} == w_half);

    assign o_s_ready = !i_full;
    assign o_push    = i_s_valid && !i_full;

    always_comb begin
        o_entry.freq = i_freq;
        o_entry.tim  = i_time;
        priority if (w_illegal) begin
            o_entry.cls = fbsg_pkg::CLS_ILLEGAL;
        end else if (i_freq == '0) begin
            o_entry.cls = fbsg_pkg::CLS_DC;
        end else if (w_nyq) begin
            o_entry.cls = fbsg_pkg::CLS_NYQ;
        end else begin
            o_entry.cls = fbsg_pkg::CLS_PAIR;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fbsg_back.sv =====
// fbsg_back: phase reduction, angle division, horner sine/cosine pipeline
// and output register; depends on fbsg_pkg
`default_nettype none

module fbsg_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [fbsg_pkg::LEN_W-1:0]  i_block_length,
    input  wire logic                        i_q_valid,
    input  wire fbsg_pkg::t_entry            i_q_entry,
    output logic                             o_q_pop,
    output logic                             o_m_valid,
    input  wire logic                        i_m_ready,
    output logic [fbsg_pkg::SMP_W-1:0]       o_cos,
    output logic [fbsg_pkg::SMP_W-1:0]       o_sin,
    output logic [fbsg_pkg::CNT_W-1:0]       o_count
);

    localparam int unsigned ST_MOD0  = 1;
    localparam int unsigned ST_Q1    = ST_MOD0 + fbsg_pkg::MOD_STG;
    localparam int unsigned ST_DIV0  = ST_Q1 + 3;
    localparam int unsigned ST_X     = ST_DIV0 + fbsg_pkg::DIV_STG;
    localparam int unsigned ST_STEP0 = ST_X + 1;
    localparam int unsigned NSTEPST  = 2 * fbsg_pkg::STEPS;
    localparam int unsigned XST      = NSTEPST - 2;
    localparam int unsigned NSTG     = ST_STEP0 + NSTEPST;

    localparam int unsigned LW = fbsg_pkg::LEN_W;
    localparam int unsigned PW = fbsg_pkg::PRD_W;
    localparam int unsigned NW = fbsg_pkg::NUM_W;
    localparam int unsigned XW = fbsg_pkg::X_W;
    localparam int unsigned TW = fbsg_pkg::T_W;
    localparam int unsigned KW = fbsg_pkg::NIB_W;

    logic w_en;
    logic [NSTG-1:0] r_vld;
    fbsg_pkg::t_side r_side [NSTG];
    fbsg_pkg::t_side n_side [NSTG];

    logic [PW-1:0] r_prod;
    logic [LW-1:0] r_mrem [fbsg_pkg::MOD_STG];
    logic [LW-1:0] n_mrem [fbsg_pkg::MOD_STG];
    logic [PW-1:0] r_mdiv [fbsg_pkg::MOD_STG-1];
    logic [PW-1:0] w_msrc [fbsg_pkg::MOD_STG];

    logic [LW-1:0] r_qr, n_qr, r_rr, n_rr;
    logic [1:0]    n_quad;
    logic          n_fold;
    logic [NW-1:0] r_num;

    fbsg_pkg::t_div r_dq [fbsg_pkg::DIV_STG];
    fbsg_pkg::t_div n_dq [fbsg_pkg::DIV_STG];
    fbsg_pkg::t_div w_dsrc [fbsg_pkg::DIV_STG];
    logic [NW-1:0] r_dnum [fbsg_pkg::DIV_STG-1];
    logic [NW-1:0] w_dnsrc [fbsg_pkg::DIV_STG];

    logic [XW-1:0] r_x, r_x2;
    logic [XW-1:0] r_sx  [XST];
    logic [XW-1:0] r_sx2 [XST];
    logic [XW-1:0] w_x_in  [XST+1];
    logic [XW-1:0] w_x2_in [XST+1];
    logic [TW-1:0] w_ts_in [NSTEPST];
    logic [TW-1:0] w_tc_in [NSTEPST];
    logic [TW-1:0] r_ts [NSTEPST];
    logic [TW-1:0] r_tc [NSTEPST];
    logic [TW-1:0] n_ts [NSTEPST];
    logic [TW-1:0] n_tc [NSTEPST];

    logic [LW+1:0] w_p4, w_n1, w_n2, w_n3;
    logic [TW-1:0] w_sa, w_ca;
    logic [fbsg_pkg::MAG_W-1:0] w_ms, w_mc;
    logic [fbsg_pkg::SMP_W-1:0] n_cos, n_sin;
    logic [fbsg_pkg::CNT_W-1:0] n_count;
    fbsg_pkg::t_side w_last;
    logic r_out_valid;
    logic [fbsg_pkg::SMP_W-1:0] r_cos, r_sin;
    logic [fbsg_pkg::CNT_W-1:0] r_count;

    assign w_en    = !r_out_valid || i_m_ready;
    assign o_q_pop = w_en;

    // sideband shift line, quadrant and fold filled in on the way
    always_comb begin
        n_side[0].cls  = i_q_entry.cls;
        n_side[0].kodd = i_q_entry.tim[0];
        n_side[0].quad = fbsg_pkg::QUAD_0;
        n_side[0].fold = 1'b0;
        for (int i = 1; i < NSTG; i++) begin
            n_side[i] = r_side[i-1];
        end
        n_side[ST_Q1].quad   = n_quad;
        n_side[ST_Q1+1].fold = n_fold;
    end

    // phase f*k mod n, four bits a stage
    for (genvar j = 0; j < fbsg_pkg::MOD_STG; j++) begin : g_mod
        if (j == 0) begin : g_first
            assign w_msrc[j] = r_prod;
            assign n_mrem[j] = fbsg_pkg::mod_nib('0, w_msrc[j][PW-1 -: KW], i_block_length);
        end else begin : g_next
            assign w_msrc[j] = r_mdiv[j-1];
            assign n_mrem[j] = fbsg_pkg::mod_nib(r_mrem[j-1], w_msrc[j][PW-1 -: KW],
                                                 i_block_length);
        end
    end

    // quadrant and remainder
    assign w_p4 = {r_mrem[fbsg_pkg::MOD_STG-1], 2'b00};
    assign w_n1 = (LW + 2)'(i_block_length);
    assign w_n2 = (LW + 2)'({i_block_length, 1'b0});
    assign w_n3 = w_n1 + w_n2;

    always_comb begin
        priority if (w_p4 >= w_n3) begin
            n_quad = fbsg_pkg::QUAD_3;
            n_qr   = LW'(w_p4 - w_n3);
        end else if (w_p4 >= w_n2) begin
            n_quad = fbsg_pkg::QUAD_2;
            n_qr   = LW'(w_p4 - w_n2);
        end else if (w_p4 >= w_n1) begin
            n_quad = fbsg_pkg::QUAD_1;
            n_qr   = LW'(w_p4 - w_n1);
        end else begin
            n_quad = fbsg_pkg::QUAD_0;
            n_qr   = LW'(w_p4);
        end
    end

    assign n_fold = ({r_qr, 1'b0} > {1'b0, i_block_length});
    assign n_rr   = n_fold ? (i_block_length - r_qr) : r_qr;

    // angle x = (rr*pi/2 + n/2) / n, four quotient bits a stage
    for (genvar j = 0; j < fbsg_pkg::DIV_STG; j++) begin : g_div
        if (j == 0) begin : g_first
            assign w_dsrc[j]  = '0;
            assign w_dnsrc[j] = r_num;
        end else begin : g_next
            assign w_dsrc[j]  = r_dq[j-1];
            assign w_dnsrc[j] = r_dnum[j-1];
        end
        assign n_dq[j] = fbsg_pkg::div_nib(w_dsrc[j], w_dnsrc[j][NW-1 -: KW], i_block_length);
    end

    // horner: even stage multiplies, odd divides+subtracts (not last sine)
    for (genvar s = 0; s < NSTEPST; s++) begin : g_step
        if (s == 0) begin : g_first
            assign w_x_in[s]  = r_x;
            assign w_x2_in[s] = r_x2;
            assign w_ts_in[s] = fbsg_pkg::Q30_ONE;
            assign w_tc_in[s] = fbsg_pkg::Q30_ONE;
        end else begin : g_next
            if (s <= XST) begin : g_xfwd
                assign w_x_in[s]  = r_sx[s-1];
                assign w_x2_in[s] = r_sx2[s-1];
            end
            assign w_ts_in[s] = r_ts[s-1];
            assign w_tc_in[s] = r_tc[s-1];
        end
        if (s % 2 == 0) begin : g_mul
            if (s / 2 < fbsg_pkg::STEPS - 1) begin : g_poly
                assign n_ts[s] = TW'(fbsg_pkg::mul_q30(w_x2_in[s], w_ts_in[s]));
            end else begin : g_final
                assign n_ts[s] = TW'(fbsg_pkg::mul_q30(w_x_in[s], w_ts_in[s]));
            end
            assign n_tc[s] = TW'(fbsg_pkg::mul_q30(w_x2_in[s], w_tc_in[s]));
        end else begin : g_sub
            if (s / 2 < fbsg_pkg::STEPS - 1) begin : g_poly
                assign n_ts[s] = fbsg_pkg::Q30_ONE - TW'(fbsg_pkg::div_const(
                                 w_ts_in[s][XW-1:0], fbsg_pkg::SIN_RCP[s/2]));
            end else begin : g_final
                assign n_ts[s] = w_ts_in[s];
            end
            assign n_tc[s] = fbsg_pkg::Q30_ONE - TW'(fbsg_pkg::div_const(
                             w_tc_in[s][XW-1:0], fbsg_pkg::COS_RCP[s/2]));
        end
    end

    // sample conversion and column selection
    assign w_last = r_side[NSTG-1];
    assign w_sa   = w_last.fold ? r_tc[NSTEPST-1] : r_ts[NSTEPST-1];
    assign w_ca   = w_last.fold ? r_ts[NSTEPST-1] : r_tc[NSTEPST-1];
    assign w_ms   = fbsg_pkg::to_mag(w_sa);
    assign w_mc   = fbsg_pkg::to_mag(w_ca);

    always_comb begin
        n_cos   = '0;
        n_sin   = '0;
        n_count = fbsg_pkg::CNT_NONE;
        unique case (w_last.cls)
            fbsg_pkg::CLS_ILLEGAL: begin
                n_count = fbsg_pkg::CNT_NONE;
            end
            fbsg_pkg::CLS_DC: begin
                n_cos   = fbsg_pkg::SMP_MAX;
                n_count = fbsg_pkg::CNT_ONE;
            end
            fbsg_pkg::CLS_NYQ: begin
                n_cos   = w_last.kodd ? fbsg_pkg::SMP_MAX : fbsg_pkg::SMP_MIN;
                n_count = fbsg_pkg::CNT_ONE;
            end
            default: begin
                n_count = fbsg_pkg::CNT_TWO;
                unique case (w_last.quad)
                    fbsg_pkg::QUAD_0: begin
                        n_cos = fbsg_pkg::to_sample(w_mc, 1'b0);
                        n_sin = fbsg_pkg::to_sample(w_ms, 1'b0);
                    end
                    fbsg_pkg::QUAD_1: begin
                        n_cos = fbsg_pkg::to_sample(w_ms, 1'b1);
                        n_sin = fbsg_pkg::to_sample(w_mc, 1'b0);
                    end
                    fbsg_pkg::QUAD_2: begin
                        n_cos = fbsg_pkg::to_sample(w_mc, 1'b1);
                        n_sin = fbsg_pkg::to_sample(w_ms, 1'b1);
                    end
                    default: begin
                        n_cos = fbsg_pkg::to_sample(w_ms, 1'b0);
                        n_sin = fbsg_pkg::to_sample(w_mc, 1'b1);
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[NSTG-2:0], i_q_valid};
            r_out_valid <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NSTG; i++) begin
                r_side[i] <= n_side[i];
            end
            r_prod <= PW'(i_q_entry.freq) * PW'(i_q_entry.tim);
            for (int j = 0; j < fbsg_pkg::MOD_STG; j++) begin
                r_mrem[j] <= n_mrem[j];
            end
            for (int j = 0; j < fbsg_pkg::MOD_STG - 1; j++) begin
                r_mdiv[j] <= {w_msrc[j][PW-KW-1:0], {KW{1'b0}}};
            end
            r_qr  <= n_qr;
            r_rr  <= n_rr;
            r_num <= NW'(r_rr) * NW'(fbsg_pkg::HALF_PI_Q30) + NW'(i_block_length >> 1);
            for (int j = 0; j < fbsg_pkg::DIV_STG; j++) begin
                r_dq[j] <= n_dq[j];
            end
            for (int j = 0; j < fbsg_pkg::DIV_STG - 1; j++) begin
                r_dnum[j] <= {w_dnsrc[j][NW-KW-1:0], {KW{1'b0}}};
            end
            r_x  <= r_dq[fbsg_pkg::DIV_STG-1].quo;
            r_x2 <= fbsg_pkg::mul_q30(r_dq[fbsg_pkg::DIV_STG-1].quo,
                                      TW'(r_dq[fbsg_pkg::DIV_STG-1].quo));
            for (int s = 0; s < XST; s++) begin
                r_sx[s]  <= w_x_in[s];
                r_sx2[s] <= w_x2_in[s];
            end
            for (int s = 0; s < NSTEPST; s++) begin
                r_ts[s] <= n_ts[s];
                r_tc[s] <= n_tc[s];
            end
            r_cos   <= n_cos;
            r_sin   <= n_sin;
            r_count <= n_count;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_cos     = r_cos;
    assign o_sin     = r_sin;
    assign o_count   = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/fourier_basis_sample_generator_core.sv =====
// fourier_basis_sample_generator_core: top level, configuration registers,
// front classifier, request queue and arithmetic back end
// depends on fbsg_pkg, fbsg_front, fbsg_fifo, fbsg_back
// an accepted input beat passes through the queue, the back end stages and the output register
// throughput: one beat per cycle while the output is not stalled, set by the fully pipelined mod/divide/horner back end
// the whole back end stalls together while the output beat waits
// synchronous active-low reset clears queue, stage valids, output valid and
// restores block_length to 64 and lowest_index to 0
`default_nettype none

module fourier_basis_sample_generator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // freq_index[9:0], time_index[19:10], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // cos_value[15:0], sin_value[31:16]
    output logic [1:0]       m_axis_tuser,   // column_count[1:0]
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);

    logic [fbsg_pkg::LEN_W-1:0] r_block_length;
    logic [fbsg_pkg::IDX_W-1:0] r_lowest_index;
    logic w_full, w_empty, w_push, w_pop;
    fbsg_pkg::t_entry w_entry, w_head;
    logic [fbsg_pkg::SMP_W-1:0] w_cos, w_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= 11'd64;
            r_lowest_index <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fbsg_pkg::REG_BLOCK_LENGTH: r_block_length <= i_cfg_data;
                default:                    r_lowest_index <= i_cfg_data[9:0];
            endcase
        end
    end

    fbsg_front u_front (
        .i_s_valid      (s_axis_tvalid),
        .i_freq         (s_axis_tdata[9:0]),
        .i_time         (s_axis_tdata[19:10]),
        .i_block_length (r_block_length),
        .i_lowest_index (r_lowest_index),
        .i_full         (w_full),
        .o_s_ready      (s_axis_tready),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    fbsg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_entry (w_head)
    );

    fbsg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_block_length (r_block_length),
        .i_q_valid      (!w_empty),
        .i_q_entry      (w_head),
        .o_q_pop        (w_pop),
        .o_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .o_cos          (w_cos),
        .o_sin          (w_sin),
        .o_count        (m_axis_tuser)
    );

    assign m_axis_tdata = {w_sin, w_cos};

    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == fbsg_pkg::CNT_NONE) |-> (m_axis_tdata == '0))
        else $error("illegal index beat carries non-zero samples");

    a_single_sin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == fbsg_pkg::CNT_ONE) |-> (m_axis_tdata[31:16] == '0))
        else $error("single column beat carries a sine sample");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !s_axis_tready)
        else $error("input accepted while queue full");

    a_push_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (s_axis_tvalid && s_axis_tready))
        else $error("queue push without input beat");

endmodule

`default_nettype wire
